/* rtl/core/ddws_pkg.sv */
// ----------------------------------------------------------------------------
// ddws_pkg
// Shared types, constants and fixed-point helpers for the wheel speed unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ddws_pkg;

  localparam int unsigned SpeedW  = 24;
  localparam int unsigned HsepW   = 20;
  localparam int unsigned InvRW   = 24;
  localparam int unsigned LimW    = 23;
  localparam int unsigned AgeW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  // multiplier operand and product widths
  localparam int unsigned OpAW    = 30;
  localparam int unsigned OpBW    = 25;
  localparam int unsigned ProdW   = OpAW + OpBW;
  localparam int unsigned RndW    = ProdW - 16;
  localparam int unsigned TermW   = 29;

  localparam logic [CfgIdxW-1:0] RegHalfSep  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInvRad   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimit    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTimeout  = 2'd3;

  localparam logic [HsepW-1:0] HalfSepReset = 20'd9830;
  localparam logic [InvRW-1:0] InvRadReset  = 24'd1310720;
  localparam logic [LimW-1:0]  LimitReset   = 23'd655360;
  localparam logic [AgeW-1:0]  TimeoutReset = 16'd4;
  localparam logic [AgeW-1:0]  AgeMax       = 16'hFFFF;

  localparam logic FuncCmd  = 1'b0;
  localparam logic FuncTick = 1'b1;

  localparam logic CauseCmd  = 1'b0;
  localparam logic CauseStop = 1'b1;

  localparam logic signed [RndW-1:0] QMax = 39'sd8388607;
  localparam logic signed [RndW-1:0] QMin = -39'sd8388608;

  typedef struct packed {
    logic                     func;
    logic signed [SpeedW-1:0] linear_speed;
    logic signed [SpeedW-1:0] turn_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] left_speed;
    logic signed [SpeedW-1:0] right_speed;
    logic                     cause;
  } out_item_t;

  typedef struct packed {
    logic cmd;
    logic tick;
  } wdog_ctl_t;

  // Q.32 to Q.16, round half up
  function automatic logic signed [RndW-1:0] rnd_q16(input logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] s;
    s = x + ProdW'(32768);
    return s[ProdW-1:16];
  endfunction

  function automatic logic signed [SpeedW-1:0] clamp_speed(
    input logic signed [RndW-1:0] x,
    input logic        [LimW-1:0] lim
  );
    logic signed [RndW-1:0] hi;
    logic signed [RndW-1:0] lo;
    logic signed [RndW-1:0] y;
    if (lim != '0) begin
      hi = signed'({{(RndW-LimW){1'b0}}, lim});
      lo = -hi;
    end else begin
      hi = QMax;
      lo = QMin;
    end
    if (x > hi) begin
      y = hi;
    end else if (x < lo) begin
      y = lo;
    end else begin
      y = x;
    end
    return y[SpeedW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/diff_drive_wheel_speed_watchdog_unit.sv */
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_watchdog_unit
// Differential-drive wheel speeds from velocity commands, with a tick watchdog.
// ----------------------------------------------------------------------------
// A velocity command is worked in order after its transfer: three products
// go one after another through a single multiplier (turn term, left, right),
// with a rounding step for the turn term; the result is loaded in the emit
// state, which a tick that fires the stop result also enters.
// The input is not ready while an item is in work or its result cannot yet be
// loaded into the output register.
`default_nettype none

module diff_drive_wheel_speed_watchdog_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire ddws_pkg::in_item_t                 in_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      ddws_pkg::out_item_t                out_data,
  input  wire logic                               cfg_we,
  input  wire logic [ddws_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [ddws_pkg::CfgW-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_RND_T,
    ST_MUL_L,
    ST_MUL_R,
    ST_EMIT
  } state_t;

  state_t state;

  logic [ddws_pkg::HsepW-1:0] half_sep;
  logic [ddws_pkg::InvRW-1:0] inv_rad;
  logic [ddws_pkg::LimW-1:0]  limit;
  logic [ddws_pkg::AgeW-1:0]  timeout;

  logic signed [ddws_pkg::SpeedW-1:0] lin;
  logic signed [ddws_pkg::SpeedW-1:0] turn;
  logic signed [ddws_pkg::TermW-1:0]  term;
  logic signed [ddws_pkg::SpeedW-1:0] left;
  logic                               stop_pend;

  logic                                 mul_en;
  logic signed [ddws_pkg::OpAW-1:0]     op_a;
  logic signed [ddws_pkg::OpBW-1:0]     op_b;
  logic signed [ddws_pkg::ProdW-1:0]    prod;
  logic signed [ddws_pkg::RndW-1:0]     prod_rnd;
  logic signed [ddws_pkg::SpeedW-1:0]   prod_lim;
  logic signed [ddws_pkg::OpAW-1:0]     lin_ext;
  logic signed [ddws_pkg::OpAW-1:0]     term_ext;

  logic                 in_xfer;
  logic                 out_free;
  ddws_pkg::wdog_ctl_t  wctl;
  logic                 fire;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_sep <= ddws_pkg::HalfSepReset;
      inv_rad  <= ddws_pkg::InvRadReset;
      limit    <= ddws_pkg::LimitReset;
      timeout  <= ddws_pkg::TimeoutReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddws_pkg::RegHalfSep: half_sep <= cfg_data[ddws_pkg::HsepW-1:0];
        ddws_pkg::RegInvRad:  inv_rad  <= cfg_data[ddws_pkg::InvRW-1:0];
        ddws_pkg::RegLimit:   limit    <= cfg_data[ddws_pkg::LimW-1:0];
        ddws_pkg::RegTimeout: timeout  <= cfg_data[ddws_pkg::AgeW-1:0];
        default: ;
      endcase
    end
  end

  assign wctl.cmd  = in_xfer && (in_data.func == ddws_pkg::FuncCmd);
  assign wctl.tick = in_xfer && (in_data.func == ddws_pkg::FuncTick);

  ddws_wdog u_wdog (
    .clk     (clk),
    .rst     (rst),
    .ctl     (wctl),
    .timeout (timeout),
    .fire    (fire)
  );

  assign lin_ext  = ddws_pkg::OpAW'(lin);
  assign term_ext = ddws_pkg::OpAW'(term);

  always_comb begin
    mul_en = 1'b0;
    op_a   = ddws_pkg::OpAW'(turn);
    op_b   = signed'({{(ddws_pkg::OpBW-ddws_pkg::HsepW){1'b0}}, half_sep});
    case (state)
      ST_MUL_T: begin
        mul_en = 1'b1;
      end
      ST_MUL_L: begin
        mul_en = 1'b1;
        op_a   = lin_ext - term_ext;
        op_b   = signed'({{(ddws_pkg::OpBW-ddws_pkg::InvRW){1'b0}}, inv_rad});
      end
      ST_MUL_R: begin
        mul_en = 1'b1;
        op_a   = lin_ext + term_ext;
        op_b   = signed'({{(ddws_pkg::OpBW-ddws_pkg::InvRW){1'b0}}, inv_rad});
      end
      default: ;
    endcase
  end

  ddws_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_rnd = ddws_pkg::rnd_q16(prod);
  assign prod_lim = ddws_pkg::clamp_speed(prod_rnd, limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      stop_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            lin  <= in_data.linear_speed;
            turn <= in_data.turn_rate;
            if (in_data.func == ddws_pkg::FuncCmd) begin
              stop_pend <= 1'b0;
              state     <= ST_MUL_T;
            end else if (fire) begin
              stop_pend <= 1'b1;
              state     <= ST_EMIT;
            end
          end
        end
        ST_MUL_T: state <= ST_RND_T;
        ST_RND_T: begin
          term  <= prod_rnd[ddws_pkg::TermW-1:0];
          state <= ST_MUL_L;
        end
        ST_MUL_L: state <= ST_MUL_R;
        ST_MUL_R: begin
          left  <= prod_lim;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (stop_pend) begin
              out_data.left_speed  <= '0;
              out_data.right_speed <= '0;
              out_data.cause       <= ddws_pkg::CauseStop;
            end else begin
              out_data.left_speed  <= left;
              out_data.right_speed <= prod_lim;
              out_data.cause       <= ddws_pkg::CauseCmd;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ddws_mul.sv */
// ----------------------------------------------------------------------------
// ddws_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ddws_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [ddws_pkg::OpAW-1:0]    op_a,
  input  wire logic signed [ddws_pkg::OpBW-1:0]    op_b,
  output      logic signed [ddws_pkg::ProdW-1:0]   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ddws_pkg::ProdW'(op_a) * ddws_pkg::ProdW'(op_b);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ddws_wdog.sv */
// ----------------------------------------------------------------------------
// ddws_wdog
// Command age counter and stopped flag; flags the tick that fires the stop.
// ----------------------------------------------------------------------------
`default_nettype none

module ddws_wdog (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ddws_pkg::wdog_ctl_t            ctl,
  input  wire logic [ddws_pkg::AgeW-1:0]      timeout,
  output      logic                           fire
);

  logic [ddws_pkg::AgeW-1:0] age;
  logic [ddws_pkg::AgeW-1:0] age_next;
  logic                      stopped;

  assign age_next = (age == ddws_pkg::AgeMax) ? age : age + 1'b1;
  assign fire     = ctl.tick && (timeout != '0) && (age_next > timeout) && !stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      age     <= '0;
      stopped <= 1'b1;
    end else if (ctl.cmd) begin
      age     <= '0;
      stopped <= 1'b0;
    end else if (ctl.tick) begin
      age <= age_next;
      if (fire) begin
        stopped <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
